/* hw/rtl/vt100_escape_sgr_parser_macros.svh */
// Assertion macros used by the escape sequence parser RTL.
`ifndef VT100_ESCAPE_SGR_PARSER_MACROS_SVH
`define VT100_ESCAPE_SGR_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define VT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define VT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VT_ASSERT_NOW(lbl, ante, cons, msg)
`define VT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/vtsgr_pkg.sv */
// Types and constants of the escape sequence and SGR attribute parser.
package vtsgr_pkg;

  // Default width of a collected decimal parameter.
  localparam int PARAM_BITS_DEF = 16;

  // Byte codes recognised by the parser.
  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_SEMI     = 8'h3B;
  localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
  localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
  localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;
  localparam logic [7:0] BYTE_FINAL_K  = 8'h4B;
  localparam logic [7:0] BYTE_FINAL_M  = 8'h6D;

  // SGR parameter codes.
  localparam int SGR_RESET    = 0;
  localparam int SGR_BOLD     = 1;
  localparam int SGR_NORMAL   = 22;
  localparam int SGR_FG_LO    = 30;
  localparam int SGR_FG_HI    = 37;
  localparam int SGR_FG_CLEAR = 39;
  localparam int SGR_BG_LO    = 40;
  localparam int SGR_BG_HI    = 47;
  localparam int SGR_BG_CLEAR = 49;

  // Result kinds.
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_ERASE = 1'b1;

  // Parser mode, one-hot.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_CSI    = 3'b100
  } mode_t;

  // Character attributes.
  typedef struct packed {
    logic       bold;
    logic       bg_valid;
    logic [2:0] bg_color;
    logic       fg_valid;
    logic [2:0] fg_color;
  } attr_t;

endpackage

/* hw/rtl/vt100_escape_sgr_parser.sv */
// Top level of the escape sequence parser with SGR attribute tracking.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_byte_in
//   out_     output     out_valid / out_ready  out_kind, out_char_code, colours, bold
//
// One byte is taken per cycle while the block does not stall. A byte is registered
// on entry and decoded from the input register; its result, if any, then lands in
// the output register once that register is free, and is presented from there.
// The input register and the output register each hold one item, so the block
// keeps taking bytes while a result waits. It stalls only when both are full and
// the waiting result is not taken.
// Reset (rst_n low, synchronous) returns to normal mode with default attributes.
`include "vt100_escape_sgr_parser_macros.svh"

module vt100_escape_sgr_parser #(
  parameter int PARAM_BITS = vtsgr_pkg::PARAM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_char_code,
  output logic [2:0] out_fg_color,
  output logic       out_fg_valid,
  output logic [2:0] out_bg_color,
  output logic       out_bg_valid,
  output logic       out_bold
);
  import vtsgr_pkg::*;

  localparam int PROD_BITS = PARAM_BITS + 4;

  // Input register.
  logic                  in_v_r;
  logic [7:0]            byte_r;

  // Parser state.
  mode_t                 mode_r, mode_nxt;
  logic [PARAM_BITS-1:0] param_r, param_nxt;
  logic                  nonnum_r, nonnum_nxt;
  attr_t                 active_r, active_nxt;
  attr_t                 pending_r, pending_nxt;

  // Output register.
  logic                  out_v_r, out_v_nxt;
  logic                  kind_r, kind_nxt;
  logic [7:0]            char_r, char_nxt;
  attr_t                 oattr_r;

  logic                  out_free;
  logic                  proc_fire;
  logic                  is_final;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  sat_lim;
  logic [PARAM_BITS-1:0] param_acc;
  attr_t                 folded;

  // Applies one finished parameter to a copy of the attributes.
  function automatic attr_t fold_part(attr_t a_in, logic [PARAM_BITS-1:0] val,
                                      logic nonnum);
    logic [PARAM_BITS-1:0] p;
    attr_t                 a;
    p = nonnum ? '0 : val;
    a = a_in;
    if (p == PARAM_BITS'(SGR_RESET)) begin
      a = '0;
    end else if (p >= PARAM_BITS'(SGR_FG_LO) && p <= PARAM_BITS'(SGR_FG_HI)) begin
      a.fg_color = 3'(p - PARAM_BITS'(SGR_FG_LO));
      a.fg_valid = 1'b1;
    end else if (p >= PARAM_BITS'(SGR_BG_LO) && p <= PARAM_BITS'(SGR_BG_HI)) begin
      a.bg_color = 3'(p - PARAM_BITS'(SGR_BG_LO));
      a.bg_valid = 1'b1;
    end else if (p == PARAM_BITS'(SGR_BOLD)) begin
      a.bold = 1'b1;
    end else if (p == PARAM_BITS'(SGR_NORMAL)) begin
      a.bold = 1'b0;
    end else if (p == PARAM_BITS'(SGR_FG_CLEAR)) begin
      a.fg_color = 3'd0;
      a.fg_valid = 1'b0;
    end else if (p == PARAM_BITS'(SGR_BG_CLEAR)) begin
      a.bg_color = 3'd0;
      a.bg_valid = 1'b0;
    end
    return a;
  endfunction

  // Handshake: the decode stage moves whenever the output register can take a result.
  assign out_free  = !out_v_r || out_ready;
  assign proc_fire = in_v_r && out_free;
  assign in_ready  = !in_v_r || out_free;

  // Byte classes and the decimal accumulator with saturation.
  assign is_final  = (byte_r >= BYTE_FINAL_LO) && (byte_r <= BYTE_FINAL_HI);
  assign is_digit  = (byte_r >= BYTE_DIGIT_0) && (byte_r <= BYTE_DIGIT_9);
  assign digit     = 4'(byte_r - BYTE_DIGIT_0);
  assign prod      = ({4'd0, param_r} << 3) + ({4'd0, param_r} << 1)
                   + PROD_BITS'(digit);
  assign sat_lim   = {4'd0, {PARAM_BITS{1'b1}}};
  assign param_acc = (prod > sat_lim) ? {PARAM_BITS{1'b1}} : prod[PARAM_BITS-1:0];
  assign folded    = fold_part(pending_r, param_r, nonnum_r);

  // Next state and result of the byte in the input register.
  always_comb begin
    mode_nxt    = mode_r;
    param_nxt   = param_r;
    nonnum_nxt  = nonnum_r;
    active_nxt  = active_r;
    pending_nxt = pending_r;
    out_v_nxt   = 1'b0;
    kind_nxt    = KIND_CHAR;
    char_nxt    = byte_r;
    unique case (mode_r)
      MODE_ESCAPE: begin
        if (byte_r == BYTE_LBRACKET) begin
          mode_nxt    = MODE_CSI;
          param_nxt   = '0;
          nonnum_nxt  = 1'b0;
          pending_nxt = active_r;
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (is_final) begin
          if (byte_r == BYTE_FINAL_M) begin
            pending_nxt = folded;
            active_nxt  = folded;
          end else if (byte_r == BYTE_FINAL_K) begin
            out_v_nxt = 1'b1;
            kind_nxt  = KIND_ERASE;
            char_nxt  = 8'd0;
          end
          mode_nxt   = MODE_NORMAL;
          param_nxt  = '0;
          nonnum_nxt = 1'b0;
        end else if (byte_r == BYTE_SEMI) begin
          pending_nxt = folded;
          param_nxt   = '0;
          nonnum_nxt  = 1'b0;
        end else if (is_digit) begin
          param_nxt = param_acc;
        end else begin
          nonnum_nxt = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (byte_r == BYTE_ESC) begin
          mode_nxt = MODE_ESCAPE;
        end else if (byte_r != BYTE_CR) begin
          out_v_nxt = 1'b1;
        end
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      mode_r    <= MODE_NORMAL;
      param_r   <= '0;
      nonnum_r  <= 1'b0;
      active_r  <= '0;
      pending_r <= '0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (proc_fire) begin
        out_v_r   <= out_v_nxt;
        mode_r    <= mode_nxt;
        param_r   <= param_nxt;
        nonnum_r  <= nonnum_nxt;
        active_r  <= active_nxt;
        pending_r <= pending_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte_in;
    end
    if (proc_fire && out_v_nxt) begin
      kind_r  <= kind_nxt;
      char_r  <= char_nxt;
      oattr_r <= active_r;
    end
  end

  // Output ports.
  assign out_valid     = out_v_r;
  assign out_kind      = kind_r;
  assign out_char_code = char_r;
  assign out_fg_color  = oattr_r.fg_color;
  assign out_fg_valid  = oattr_r.fg_valid;
  assign out_bg_color  = oattr_r.bg_color;
  assign out_bg_valid  = oattr_r.bg_valid;
  assign out_bold      = oattr_r.bold;

  // Checks on the parser logic.
  `VT_ASSERT_NOW(a_erase_no_char, out_valid && (out_kind == KIND_ERASE), out_char_code == 8'd0, "erase item carries a character code")
  `VT_ASSERT_NOW(a_fg_default, out_valid && !out_fg_valid, out_fg_color == 3'd0, "default foreground with a colour index")
  `VT_ASSERT_NOW(a_bg_default, out_valid && !out_bg_valid, out_bg_color == 3'd0, "default background with a colour index")
  `VT_ASSERT_NEXT(a_char_out, proc_fire && (mode_r == MODE_NORMAL) && (byte_r != BYTE_ESC) && (byte_r != BYTE_CR), out_valid && (out_kind == KIND_CHAR) && (out_char_code == $past(byte_r)), "printable byte did not produce its character item")
  `VT_ASSERT_NEXT(a_no_spurious, proc_fire && (mode_r != MODE_NORMAL) && !((mode_r == MODE_CSI) && (byte_r == BYTE_FINAL_K)), !out_valid, "result item from a byte inside an escape sequence")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the escape sequence parser with SGR attribute tracking.
`timescale 1ns / 1ps

module tb_top;
  import vtsgr_pkg::*;

  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned HOLDOFF_AFTER  = 100;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_BYTES   = 950;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned NUM_CEILING    = (1 << PARAM_BITS_DEF) - 1;

  // Opening bytes: field extremes, a dropped CR, a swallowed escape, a full SGR
  // list, an unknown final byte, an erase with pending changes and an empty list.
  localparam int unsigned OPENING_LEN = 33;
  localparam logic [7:0] OPENING_BYTES [OPENING_LEN] = '{
    8'h00, 8'hFF, BYTE_CR,
    BYTE_ESC, "x", "y",
    BYTE_ESC, BYTE_LBRACKET, "1", BYTE_SEMI, "3", "6", BYTE_SEMI, "4", "5", BYTE_FINAL_M, "a",
    BYTE_ESC, BYTE_LBRACKET, "2", "2", "A", "b",
    BYTE_ESC, BYTE_LBRACKET, "3", BYTE_SEMI, "1", BYTE_FINAL_K,
    BYTE_ESC, BYTE_LBRACKET, BYTE_FINAL_M, "c"
  };

  // One result item as the output port presents it.
  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    attr_t      attr;
  } term_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_char_code;
  logic [2:0] out_fg_color;
  logic       out_fg_valid;
  logic [2:0] out_bg_color;
  logic       out_bg_valid;
  logic       out_bold;

  logic [7:0]  host_bytes [$];
  term_event_t expected_events [$];

  int unsigned bytes_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predicted parser state.
  mode_t       esc_state = MODE_NORMAL;
  int unsigned num_acc = 0;
  bit          num_junk = 1'b0;
  attr_t       live_attr = '0;
  attr_t       staged_attr = '0;

  // Pacing state of the sender and the receiver.
  int unsigned feed_gap = 0;
  int unsigned feed_calm = 0;
  int unsigned drain_stall = 0;
  int unsigned drain_calm = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  always #5 clk = ~clk;

  vt100_escape_sgr_parser dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_in    (in_byte_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_char_code (out_char_code),
    .out_fg_color  (out_fg_color),
    .out_fg_valid  (out_fg_valid),
    .out_bg_color  (out_bg_color),
    .out_bg_valid  (out_bg_valid),
    .out_bold      (out_bold)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Decimal text of a number, as the host would send it.
  task automatic push_number(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) host_bytes.push_back(s[i]);
  endtask

  // A finished parameter is folded into the staged attributes; a part that
  // held anything but digits counts as a reset.
  task automatic fold_sgr_part();
    int unsigned code;
    attr_t a;
    code = num_junk ? 0 : num_acc;
    a = staged_attr;
    if (code == SGR_RESET) begin
      a = '0;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      a.fg_color = 3'(code - SGR_FG_LO);
      a.fg_valid = 1'b1;
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      a.bg_color = 3'(code - SGR_BG_LO);
      a.bg_valid = 1'b1;
    end else if (code == SGR_BOLD) begin
      a.bold = 1'b1;
    end else if (code == SGR_NORMAL) begin
      a.bold = 1'b0;
    end else if (code == SGR_FG_CLEAR) begin
      a.fg_color = '0;
      a.fg_valid = 1'b0;
    end else if (code == SGR_BG_CLEAR) begin
      a.bg_color = '0;
      a.bg_valid = 1'b0;
    end
    staged_attr = a;
    num_acc = 0;
    num_junk = 1'b0;
  endtask

  // Advances the predicted parser by one byte and queues the result it causes.
  task automatic track_terminal_byte(input logic [7:0] b);
    term_event_t ev;
    case (esc_state)
      MODE_ESCAPE: begin
        if (b == BYTE_LBRACKET) begin
          esc_state = MODE_CSI;
          num_acc = 0;
          num_junk = 1'b0;
          staged_attr = live_attr;
        end else begin
          esc_state = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI) begin
          if (b == BYTE_FINAL_M) begin
            fold_sgr_part();
            live_attr = staged_attr;
          end else if (b == BYTE_FINAL_K) begin
            ev.kind = KIND_ERASE;
            ev.char_code = '0;
            ev.attr = live_attr;
            expected_events.push_back(ev);
          end
          esc_state = MODE_NORMAL;
          num_acc = 0;
          num_junk = 1'b0;
        end else if (b == BYTE_SEMI) begin
          fold_sgr_part();
        end else if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
          num_acc = num_acc * 10 + (b - BYTE_DIGIT_0);
          if (num_acc > NUM_CEILING) num_acc = NUM_CEILING;
        end else begin
          num_junk = 1'b1;
        end
      end
      default: begin
        esc_state = MODE_NORMAL;
        if (b == BYTE_ESC) begin
          esc_state = MODE_ESCAPE;
        end else if (b != BYTE_CR) begin
          ev.kind = KIND_CHAR;
          ev.char_code = b;
          ev.attr = live_attr;
          expected_events.push_back(ev);
        end
      end
    endcase
  endtask

  // Sender: offers the next pending byte after a random gap and holds it until taken.
  always @(posedge clk) begin : feed
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        track_terminal_byte(in_byte_in);
        bytes_taken++;
        offer = 1'b0;
        if (feed_calm > 0) begin
          feed_calm--;
          feed_gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
          feed_calm = $urandom_range(20, 80);
          feed_gap = 0;
        end else begin
          feed_gap = idle_length();
        end
      end
      if (!offer) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (host_bytes.size() > 0) begin
          in_byte_in <= host_bytes.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: checks each result item and stalls at random, once for a long stretch.
  always @(posedge clk) begin : drain
    term_event_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: kind %0d char %02h fg %0d/%0d bg %0d/%0d bold %0d",
                     out_kind, out_char_code, out_fg_valid, out_fg_color,
                     out_bg_valid, out_bg_color, out_bold);
        end else begin
          want = expected_events.pop_front();
          if (out_kind !== want.kind || out_char_code !== want.char_code ||
              out_fg_color !== want.attr.fg_color || out_fg_valid !== want.attr.fg_valid ||
              out_bg_color !== want.attr.bg_color || out_bg_valid !== want.attr.bg_valid ||
              out_bold !== want.attr.bold) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected kind %0d char %02h fg %0d/%0d bg %0d/%0d bold %0d, got kind %0d char %02h fg %0d/%0d bg %0d/%0d bold %0d",
                       results_seen, want.kind, want.char_code, want.attr.fg_valid,
                       want.attr.fg_color, want.attr.bg_valid, want.attr.bg_color,
                       want.attr.bold, out_kind, out_char_code, out_fg_valid, out_fg_color,
                       out_bg_valid, out_bg_color, out_bold);
          end
        end
      end
      if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (drain_stall > 0) begin
        drain_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (drain_calm > 0) drain_calm--;
        else if ($urandom_range(0, 99) < 3) drain_calm = $urandom_range(30, 90);
        else drain_stall = idle_length();
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Builds the byte stream, releases reset and waits for the stream to drain.
  initial begin
    int unsigned pick;
    int unsigned parts;
    int unsigned code;
    foreach (OPENING_BYTES[i]) host_bytes.push_back(OPENING_BYTES[i]);

    // Random part: mostly text and well-formed sequences, with noise between.
    while (host_bytes.size() < OPENING_LEN + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        repeat ($urandom_range(1, 6)) host_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 46) begin
        host_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        // SGR list, or an erase that throws its list away.
        host_bytes.push_back(BYTE_ESC);
        host_bytes.push_back(BYTE_LBRACKET);
        parts = $urandom_range(0, 4);
        for (int i = 0; i < parts; i++) begin
          if (i > 0) host_bytes.push_back(BYTE_SEMI);
          case ($urandom_range(0, 7))
            0: code = SGR_RESET;
            1: code = SGR_BOLD;
            2: code = SGR_NORMAL;
            3: code = SGR_FG_CLEAR;
            4: code = SGR_BG_CLEAR;
            5: code = SGR_FG_LO + $urandom_range(0, 7);
            6: code = SGR_BG_LO + $urandom_range(0, 7);
            default: code = $urandom_range(0, 60);
          endcase
          if ($urandom_range(0, 7) == 0) host_bytes.push_back(BYTE_DIGIT_0);
          if ($urandom_range(0, 15) != 0) push_number(code);
        end
        host_bytes.push_back(pick < 78 ? BYTE_FINAL_M : BYTE_FINAL_K);
      end else if (pick < 95) begin
        // Malformed sequence: huge numbers and stray bytes, then any final byte.
        host_bytes.push_back(BYTE_ESC);
        host_bytes.push_back(BYTE_LBRACKET);
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 3))
            0: push_number($urandom_range(NUM_CEILING - 5, 999999));
            1: host_bytes.push_back(8'($urandom_range(8'h00, 8'h3F)));
            2: host_bytes.push_back(8'($urandom_range(8'h7F, 8'hFF)));
            default: host_bytes.push_back(BYTE_SEMI);
          endcase
        end
        case ($urandom_range(0, 2))
          0: host_bytes.push_back(BYTE_FINAL_M);
          1: host_bytes.push_back(BYTE_FINAL_K);
          default: host_bytes.push_back(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
        endcase
      end else begin
        // Escape followed by an arbitrary byte, usually swallowed.
        host_bytes.push_back(BYTE_ESC);
        host_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    bytes_total = host_bytes.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while ((bytes_taken < bytes_total || expected_events.size() != 0) &&
           quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    if (quiet_cycles < QUIET_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk);

    if (quiet_cycles < QUIET_LIMIT && mismatches == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/vtsgr_pkg.sv
hw/rtl/vt100_escape_sgr_parser.sv
tb/tb_top.sv
